// ----- hw/rtl/modbus_register_response_checker_top_defines.svh -----
// Assertion macros shared by the checker modules.
`ifndef MODBUS_REGISTER_RESPONSE_CHECKER_TOP_DEFINES_SVH
`define MODBUS_REGISTER_RESPONSE_CHECKER_TOP_DEFINES_SVH

// Checked on every rising edge of clk outside reset.
`define MRRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define MRRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mrrc_pkg.sv -----
package mrrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] EXC_BIT = 8'h80;
  localparam logic [7:0] EXPECTED_FUNCTION_RESET = 8'd3;
  localparam int MIN_FRAME = 5;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_CRC   = 3'd2,
    ST_EXC   = 3'd3,
    ST_FUNC  = 3'd4,
    ST_TRUNC = 3'd5
  } status_t;

  typedef enum logic {
    KIND_WORD   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] word;
    logic [6:0]  index;
    status_t     status;
    logic [7:0]  exc;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    word_valid;
    logic    status_valid;
    result_t word_res;
    result_t status_res;
  } push_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/mrrc_frame.sv -----
`include "modbus_register_response_checker_top_defines.svh"

module mrrc_frame #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [7:0]      cfg_data,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  input  logic            frame_end,
  output mrrc_pkg::push_t push
);
  import mrrc_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [7:0]       expected_function;
  logic [POS_W-1:0] pos;
  logic [7:0]       d0;
  logic [7:0]       d1;
  logic [15:0]      crc;
  logic [7:0]       fn;
  logic [7:0]       bc;
  logic [7:0]       hi;
  logic [6:0]       words;

  logic [POS_W-1:0] f_pos;
  logic [7:0]       f_d0;
  logic [7:0]       f_d1;
  logic [15:0]      f_crc;
  logic [7:0]       f_fn;
  logic [7:0]       f_bc;
  logic [7:0]       f_hi;
  logic [6:0]       f_words;
  logic             word_fire;
  status_t          status;
  logic [7:0]       exc;

  always_comb begin
    f_pos = pos;
    f_d0 = d0;
    f_d1 = d1;
    f_crc = crc;
    f_fn = fn;
    f_bc = bc;
    f_hi = hi;
    word_fire = 1'b0;
    if (pos < POS_W'(MAX_FRAME_BYTES)) begin
      if (pos >= POS_W'(2)) begin
        f_crc = crc_byte(crc, d0);
        if (pos == POS_W'(3)) begin
          f_fn = d0;
        end else if (pos == POS_W'(4)) begin
          f_bc = d0;
        end else if (pos >= POS_W'(5)) begin
          if (pos[0]) begin
            f_hi = d0;
          end else if (words < bc[7:1]) begin
            word_fire = 1'b1;
          end
        end
      end
      f_d0 = d1;
      f_d1 = rx_byte;
      f_pos = pos + POS_W'(1);
    end
    f_words = words + 7'(word_fire);
  end

  always_comb begin
    exc = 8'h00;
    priority if (f_pos < POS_W'(MIN_FRAME)) begin
      status = ST_SHORT;
    end else if ({f_d1, f_d0} != f_crc) begin
      status = ST_CRC;
    end else if ((f_fn & EXC_BIT) != 8'h00) begin
      status = ST_EXC;
      exc = f_bc;
    end else if (f_fn != expected_function) begin
      status = ST_FUNC;
    end else if (10'(f_pos) < 10'(f_bc) + 10'(MIN_FRAME)) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    push.word_valid = accept && word_fire;
    push.status_valid = accept && frame_end;
    push.word_res.kind = KIND_WORD;
    push.word_res.word = {hi, d0};
    push.word_res.index = words;
    push.word_res.status = ST_OK;
    push.word_res.exc = 8'h00;
    push.word_res.last = 1'b0;
    push.status_res.kind = KIND_STATUS;
    push.status_res.word = 16'h0000;
    push.status_res.index = f_words;
    push.status_res.status = status;
    push.status_res.exc = exc;
    push.status_res.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_function <= EXPECTED_FUNCTION_RESET;
    end else if (cfg_write) begin
      expected_function <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && frame_end)) begin
      pos <= '0;
      d0 <= 8'h00;
      d1 <= 8'h00;
      crc <= CRC_INIT;
      fn <= 8'h00;
      bc <= 8'h00;
      hi <= 8'h00;
      words <= 7'd0;
    end else if (accept) begin
      pos <= f_pos;
      d0 <= f_d0;
      d1 <= f_d1;
      crc <= f_crc;
      fn <= f_fn;
      bc <= f_bc;
      hi <= f_hi;
      words <= f_words;
    end
  end

  `MRRC_ASSERT(a_pos_bound, pos <= POS_W'(MAX_FRAME_BYTES), "byte position beyond frame limit")
  `MRRC_ASSERT(a_words_bound, words <= bc[7:1], "more words than the byte count allows")
  `MRRC_ASSERT(a_end_clears, (accept && frame_end) |=> (pos == '0 && words == 7'd0), "frame state not cleared after status")

endmodule

// ----- hw/rtl/mrrc_result_fifo.sv -----
`include "modbus_register_response_checker_top_defines.svh"

module mrrc_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  mrrc_pkg::push_t   push,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output mrrc_pkg::result_t head
);
  import mrrc_pkg::*;

  result_t              entries [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;

  logic                 pop;
  logic                 push_any;
  logic [1:0]           push_n;
  result_t              first_res;

  assign pop = out_valid && !out_stall;
  assign push_any = push.word_valid || push.status_valid;
  assign push_n = 2'(push.word_valid) + 2'(push.status_valid);
  assign first_res = push.word_valid ? push.word_res : push.status_res;
  assign full = count > RES_CNT_W'(RES_DEPTH - 2);
  assign out_valid = count != '0;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_any) begin
      entries[wr_ptr] <= first_res;
    end
    if (push.word_valid && push.status_valid) begin
      entries[wr_ptr + RES_PTR_W'(1)] <= push.status_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      count <= count + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
    end
  end

  `MRRC_ASSERT(a_no_overflow, push_any |-> count <= RES_CNT_W'(RES_DEPTH - 2), "request pushed while queue lacks room")
  `MRRC_ASSERT(a_pop_count, (pop && !push_any) |=> count == $past(count) - RES_CNT_W'(1), "count did not drop on a lone pop")
  `MRRC_ASSERT(a_count_bound, count <= RES_CNT_W'(RES_DEPTH), "queue count beyond depth")
  `MRRC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "queue not empty after reset")

endmodule

// ----- hw/rtl/modbus_register_response_checker_top.sv -----
// Channel  Direction  Handshake             Payload
// in       sink       in_valid, in_stall    rx_byte, frame_end
// out      source     out_valid, out_stall  result_kind, register_word, word_index,
//                                           frame_status, exception_code, last_result
// cfg      sink       cfg_write             cfg_data (expected function code)
//
// One received byte can be taken every cycle when in_stall is low. Its word and
// status results are written into a four-entry result queue at the accepting edge,
// are offered on the output from the next cycle on, and leave the queue one per cycle
// unless stalled. in_stall is high while the queue holds three or more results, so a
// stalled output side holds the input back once three results are waiting.
// Reset is synchronous on rst and sets the expected function code to 3.

module modbus_register_response_checker_top #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [15:0] register_word,
  output logic [6:0]  word_index,
  output logic [2:0]  frame_status,
  output logic [7:0]  exception_code,
  output logic        last_result
);
  import mrrc_pkg::*;

  push_t   push;
  result_t head;
  logic    full;
  logic    accept;

  assign in_stall = full;
  assign accept = in_valid && !full;

  mrrc_frame #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .accept(accept),
    .rx_byte(rx_byte),
    .frame_end(frame_end),
    .push(push)
  );

  mrrc_result_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head(head)
  );

  assign result_kind = head.kind;
  assign register_word = head.word;
  assign word_index = head.index;
  assign frame_status = head.status;
  assign exception_code = head.exc;
  assign last_result = head.last;

endmodule

// ----- tb/sv/mrrc_tb_pkg.sv -----
package mrrc_tb_pkg;

  import mrrc_pkg::CRC_POLY;

  function automatic logic [15:0] modbus_crc_update(input logic [15:0] acc,
                                                    input logic [7:0] data);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ data[i]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

// ----- tb/sv/mrrc_response_checker.sv -----
module mrrc_response_checker #(
  parameter int FRAME_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        result_kind,
  input  logic [15:0] register_word,
  input  logic [6:0]  word_index,
  input  logic [2:0]  frame_status,
  input  logic [7:0]  exception_code,
  input  logic        last_result,
  output int          mismatch_count,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import mrrc_pkg::*;
  import mrrc_tb_pkg::*;

  logic [7:0]  fc_expected;
  logic [8:0]  rx_len;
  logic [7:0]  delay_q [2];
  logic [15:0] crc_acc;
  logic [7:0]  func_code;
  logic [7:0]  count_field;
  logic [7:0]  word_high;
  logic [6:0]  words_out;
  result_t     expected_q [$];

  task automatic clear_frame();
    rx_len = '0;
    delay_q[0] = '0;
    delay_q[1] = '0;
    crc_acc = CRC_INIT;
    func_code = '0;
    count_field = '0;
    word_high = '0;
    words_out = '0;
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < 40) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    end
    mismatch_count++;
  endtask

  task automatic predict_byte(input logic [7:0] value, input logic is_last);
    logic [8:0]  pos;
    logic [7:0]  d;
    logic [15:0] received;
    result_t     r;
    if (rx_len < FRAME_LIMIT) begin
      if (rx_len >= 2) begin
        pos = rx_len - 9'd2;
        d = delay_q[0];
        crc_acc = modbus_crc_update(crc_acc, d);
        if (pos == 1) begin
          func_code = d;
        end else if (pos == 2) begin
          count_field = d;
        end else if (pos >= 3) begin
          if (pos[0]) begin
            word_high = d;
          end else if (words_out < count_field[7:1]) begin
            r = '0;
            r.kind = KIND_WORD;
            r.word = {word_high, d};
            r.index = words_out;
            r.status = ST_OK;
            expected_q.push_back(r);
            words_out++;
          end
        end
      end
      delay_q[0] = delay_q[1];
      delay_q[1] = value;
      rx_len++;
    end
    if (is_last) begin
      received = {delay_q[1], delay_q[0]};
      r = '0;
      r.kind = KIND_STATUS;
      r.index = words_out;
      r.last = 1'b1;
      if (rx_len < MIN_FRAME) begin
        r.status = ST_SHORT;
      end else if (received != crc_acc) begin
        r.status = ST_CRC;
      end else if ((func_code & EXC_BIT) != 0) begin
        r.status = ST_EXC;
        r.exc = count_field;
      end else if (func_code != fc_expected) begin
        r.status = ST_FUNC;
      end else if (int'(rx_len) < int'(count_field) + MIN_FRAME) begin
        r.status = ST_TRUNC;
      end else begin
        r.status = ST_OK;
      end
      expected_q.push_back(r);
      clear_frame();
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result, register_word", register_word, 16'h0);
    end else begin
      want = expected_q.pop_front();
      if (result_kind !== want.kind) begin
        report_mismatch("result_kind", 16'(result_kind), 16'(want.kind));
      end
      if (register_word !== want.word) report_mismatch("register_word", register_word, want.word);
      if (word_index !== want.index) begin
        report_mismatch("word_index", 16'(word_index), 16'(want.index));
      end
      if (frame_status !== want.status) begin
        report_mismatch("frame_status", 16'(frame_status), 16'(want.status));
      end
      if (exception_code !== want.exc) begin
        report_mismatch("exception_code", 16'(exception_code), 16'(want.exc));
      end
      if (last_result !== want.last) begin
        report_mismatch("last_result", 16'(last_result), 16'(want.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fc_expected = EXPECTED_FUNCTION_RESET;
      clear_frame();
      expected_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_write) fc_expected = cfg_data;
      if (in_valid && !in_stall) predict_byte(rx_byte, frame_end);
      if (out_valid && !out_stall) check_result();
    end
    results_due <= expected_q.size();
  end

endmodule

// ----- tb/sv/tb_modbus_register_response_checker_top.sv -----
module tb_modbus_register_response_checker_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mrrc_pkg::*;
  import mrrc_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 140;

  typedef enum int {
    FR_OK,
    FR_ODD_COUNT,
    FR_EXTRA_DATA,
    FR_TRUNCATED,
    FR_EXCEPTION,
    FR_WRONG_FUNC,
    FR_BAD_CRC,
    FR_SHORT,
    FR_NOISE,
    FR_FULL_LENGTH,
    FR_OVERLONG,
    FR_KIND_COUNT
  } frame_kind_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        frame_end;
  logic        out_valid;
  logic        out_stall;
  logic        result_kind;
  logic [15:0] register_word;
  logic [6:0]  word_index;
  logic [2:0]  frame_status;
  logic [7:0]  exception_code;
  logic        last_result;
  int          mismatch_count;
  int          results_due;

  logic [7:0]  frame_bytes [$];
  logic [7:0]  expected_fc;
  int          items_sent;
  int          burst_left;
  int          quiet_cycles;

  modbus_register_response_checker_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .frame_end      (frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .register_word  (register_word),
    .word_index     (word_index),
    .frame_status   (frame_status),
    .exception_code (exception_code),
    .last_result    (last_result)
  );

  mrrc_response_checker chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .frame_end      (frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .register_word  (register_word),
    .word_index     (word_index),
    .frame_status   (frame_status),
    .exception_code (exception_code),
    .last_result    (last_result),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void append_crc();
    logic [15:0] acc;
    acc = CRC_INIT;
    foreach (frame_bytes[i]) acc = modbus_crc_update(acc, frame_bytes[i]);
    frame_bytes.push_back(acc[7:0]);
    frame_bytes.push_back(acc[15:8]);
  endfunction

  function automatic void build_frame(input frame_kind_t kind);
    int         words;
    int         count;
    int         data_n;
    int         flip;
    logic [7:0] fc;
    frame_bytes.delete();
    if (kind == FR_SHORT || kind == FR_NOISE) begin
      data_n = (kind == FR_SHORT) ? $urandom_range(1, 4) : $urandom_range(5, 20);
      repeat (data_n) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      words = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 6);
      count = 2 * words;
      data_n = count;
      fc = expected_fc;
      case (kind)
        FR_ODD_COUNT: begin
          count = count + 1;
          data_n = count;
        end
        FR_EXTRA_DATA: data_n = count + $urandom_range(1, 4);
        FR_TRUNCATED: begin
          count = count + $urandom_range(1, 6);
          data_n = $urandom_range(0, count - 1);
        end
        FR_EXCEPTION: begin
          fc = 8'($urandom_range(0, 255)) | EXC_BIT;
          count = $urandom_range(0, 255);
          data_n = 0;
        end
        FR_WRONG_FUNC: begin
          do fc = 8'($urandom_range(0, 127)); while (fc == expected_fc);
        end
        FR_FULL_LENGTH: begin
          count = 250 + $urandom_range(0, 1);
          data_n = count;
        end
        FR_OVERLONG: begin
          count = 251;
          data_n = count;
        end
        default: ;
      endcase
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(fc);
      frame_bytes.push_back(count[7:0]);
      repeat (data_n) frame_bytes.push_back(8'($urandom_range(0, 255)));
      append_crc();
      if (kind == FR_BAD_CRC) begin
        flip = $urandom_range(0, frame_bytes.size() - 1);
        frame_bytes[flip] = frame_bytes[flip] ^ (8'h01 << $urandom_range(0, 7));
      end
      if (kind == FR_OVERLONG) begin
        repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    rx_byte <= value;
    frame_end <= is_last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    burst_left--;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic write_expected_function(input logic [7:0] value);
    in_valid <= 1'b0;
    wait (results_due == 0);
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    expected_fc = value;
  endtask

  initial begin
    int          frame_no;
    int          phase_end;
    int          pick;
    frame_kind_t kind;
    logic [7:0]  fc_plan [6];
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    frame_end = 1'b0;
    expected_fc = EXPECTED_FUNCTION_RESET;
    items_sent = 0;
    burst_left = 0;
    frame_no = 0;
    fc_plan[0] = 8'd4;
    fc_plan[1] = 8'd0;
    fc_plan[2] = 8'd255;
    fc_plan[3] = 8'd3;
    fc_plan[4] = 8'($urandom_range(0, 255));
    fc_plan[5] = 8'h7F;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    frame_bytes = {8'h00};
    send_frame();
    frame_bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    frame_bytes = {8'h01, 8'h83, 8'h02};
    append_crc();
    send_frame();
    frame_bytes = {8'hFF, 8'h03, 8'h02, 8'hFF, 8'hFF};
    append_crc();
    send_frame();
    frame_bytes = {8'h00, 8'h04, 8'h00};
    append_crc();
    send_frame();
    frame_bytes = {8'h01, 8'h03, 8'h00, 8'h00, 8'h00};
    send_frame();

    foreach (fc_plan[p]) begin
      write_expected_function(fc_plan[p]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (frame_no < FR_KIND_COUNT) begin
          kind = frame_kind_t'(frame_no);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 40) kind = FR_OK;
          else if (pick < 50) kind = FR_ODD_COUNT;
          else if (pick < 58) kind = FR_EXTRA_DATA;
          else if (pick < 66) kind = FR_TRUNCATED;
          else if (pick < 74) kind = FR_EXCEPTION;
          else if (pick < 82) kind = FR_WRONG_FUNC;
          else if (pick < 89) kind = FR_BAD_CRC;
          else if (pick < 94) kind = FR_SHORT;
          else if (pick < 98) kind = FR_NOISE;
          else if (pick < 99) kind = FR_FULL_LENGTH;
          else kind = FR_OVERLONG;
        end
        build_frame(kind);
        send_frame();
        frame_no++;
      end
    end

    in_valid <= 1'b0;
    wait (results_due == 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // The receiver also holds off for long stretches so that the result queue
  // fills and the block stalls incoming requests.
  initial begin
    int cycle_no;
    int hold_left;
    int mode;
    out_stall = 1'b0;
    cycle_no = 0;
    hold_left = 0;
    mode = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      cycle_no++;
      if (cycle_no % 1000 == 400) hold_left = 150;
      if (cycle_no % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (cycle_no % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
